// ===== hw/rtl/plk_pkg.sv =====
// Shared types and constants for the positional list engine.
`default_nettype none

package plk_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int CMD_W        = 3;
  localparam int POS_W        = 8;
  localparam int STAT_W       = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND   = 3'd0,
    CMD_INSERT   = 3'd1,
    CMD_DELETE   = 3'd2,
    CMD_FIND     = 3'd3,
    CMD_CLEAR    = 3'd4,
    CMD_TRAVERSE = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_BAD_POS   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_APPEND,
    OP_INSERT,
    OP_DELETE,
    OP_ROTATE
  } cell_op_t;

endpackage

`default_nettype wire

// ===== hw/rtl/positional_list_engine_core.sv =====
// Top level of the positional list engine: command decode, cell chain, result register.
//
//   channel   signals                                               direction
//   in        in_valid, in_ready, command, position, value           in
//   out       out_valid, out_ready, status, found_position,
//             element, length, last                                  out
//
// Append, insert, delete and clear act in the cycle of the transaction;
// insert and delete shift the cells from the position on, and clear only
// resets the length. Find registers the compare match of every occupied
// cell, then loads its priority encode. Traverse rotates the occupied
// cells once per emitted element; an empty list gives one ST_EMPTY result.
// One command is in work at a time; a stalled result register holds the
// chain. Reset empties the list at once; no clearing pass.
`default_nettype none

module positional_list_engine_core #(
  parameter int CAPACITY = plk_pkg::CAPACITY_DEF,
  localparam int CW      = $clog2(CAPACITY + 1),
  localparam int WW      = (CW > plk_pkg::POS_W) ? CW + 1 : plk_pkg::POS_W + 1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [plk_pkg::CMD_W-1:0]          command,
  input  logic [plk_pkg::POS_W-1:0]          position,
  input  logic signed [plk_pkg::DATA_W-1:0]  value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [plk_pkg::STAT_W-1:0]         status,
  output logic [CW-1:0]                      found_position,
  output logic signed [plk_pkg::DATA_W-1:0]  element,
  output logic [CW-1:0]                      length,
  output logic                               last
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIND,
    S_TRAV
  } state_t;

  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  state_t                     state;
  logic [CW-1:0]              fill;
  logic [CW-1:0]              fill_next;
  logic [CW-1:0]              tcnt;
  logic [CAPACITY-1:0]        match_q;
  logic [CAPACITY-1:0]        match_v;
  logic [plk_pkg::DATA_W-1:0] cell_q [CAPACITY];
  logic [plk_pkg::DATA_W-1:0] din;

  logic                       out_free;
  logic                       out_load;
  logic                       accept;
  logic [plk_pkg::POS_W-1:0]  pos_eff;
  logic [WW-1:0]              pos_w;
  logic [WW-1:0]              fill_w;
  logic [WW-1:0]              slot_w;
  logic [CW-1:0]              slot;
  plk_pkg::cell_op_t          cmd_op;
  plk_pkg::cell_op_t          cell_op;
  plk_pkg::status_t           res_status;
  logic                       emit_now;
  logic                       go_find;
  logic                       go_trav;
  logic [CW-1:0]              find_pos;
  logic                       find_hit;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign din      = value;
  assign out_load = (accept && emit_now) ||
                    ((state == S_FIND || state == S_TRAV) && out_free);

  assign pos_eff = (position == '0) ? plk_pkg::POS_W'(1) : position;
  assign pos_w   = WW'(pos_eff);
  assign fill_w  = WW'(fill);
  assign slot_w  = pos_w - WW'(1);
  assign slot    = slot_w[CW-1:0];

  always_comb begin
    cmd_op     = plk_pkg::OP_HOLD;
    res_status = plk_pkg::ST_OK;
    fill_next  = fill;
    emit_now   = 1'b0;
    go_find    = 1'b0;
    go_trav    = 1'b0;
    unique case (command)
      plk_pkg::CMD_APPEND: begin
        emit_now = 1'b1;
        if (fill == CAP_C) begin
          res_status = plk_pkg::ST_FULL;
        end else begin
          cmd_op    = plk_pkg::OP_APPEND;
          fill_next = fill + CW'(1);
        end
      end
      plk_pkg::CMD_INSERT: begin
        emit_now = 1'b1;
        if (pos_w > fill_w + WW'(1)) begin
          res_status = plk_pkg::ST_BAD_POS;
        end else if (fill == CAP_C) begin
          res_status = plk_pkg::ST_FULL;
        end else begin
          cmd_op    = plk_pkg::OP_INSERT;
          fill_next = fill + CW'(1);
        end
      end
      plk_pkg::CMD_DELETE: begin
        emit_now = 1'b1;
        if (fill == '0) begin
          res_status = plk_pkg::ST_EMPTY;
        end else if (pos_w > fill_w) begin
          res_status = plk_pkg::ST_BAD_POS;
        end else begin
          cmd_op    = plk_pkg::OP_DELETE;
          fill_next = fill - CW'(1);
        end
      end
      plk_pkg::CMD_FIND: begin
        go_find = 1'b1;
      end
      plk_pkg::CMD_CLEAR: begin
        emit_now  = 1'b1;
        fill_next = '0;
      end
      plk_pkg::CMD_TRAVERSE: begin
        if (fill == '0) begin
          emit_now   = 1'b1;
          res_status = plk_pkg::ST_EMPTY;
        end else begin
          go_trav = 1'b1;
        end
      end
      default: begin
        emit_now = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (accept) cell_op = cmd_op;
    else if (state == S_TRAV && out_free) cell_op = plk_pkg::OP_ROTATE;
    else cell_op = plk_pkg::OP_HOLD;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [plk_pkg::DATA_W-1:0] left_d;
    logic [plk_pkg::DATA_W-1:0] right_d;

    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_q[g-1];
    end

    if (g == CAPACITY - 1) begin : g_lastc
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_q[g+1];
    end

    plk_cell #(
      .CAPACITY (CAPACITY),
      .INDEX    (g)
    ) u_cell (
      .clk   (clk),
      .op    (cell_op),
      .fill  (fill),
      .slot  (slot),
      .din   (din),
      .left  (left_d),
      .right (right_d),
      .head  (cell_q[0]),
      .q     (cell_q[g]),
      .match (match_v[g])
    );
  end

  always_comb begin
    find_pos = '0;
    find_hit = 1'b0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        find_pos = CW'(i + 1);
        find_hit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go_find && accept) match_q <= match_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      fill      <= '0;
      tcnt      <= '0;
    end else begin
      if (out_valid && out_ready && !out_load) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            fill <= fill_next;
            tcnt <= '0;
            if (emit_now) begin
              out_valid      <= 1'b1;
              status         <= res_status;
              found_position <= '0;
              element        <= '0;
              length         <= fill_next;
              last           <= 1'b1;
            end
            if (go_find) state <= S_FIND;
            if (go_trav) state <= S_TRAV;
          end
        end
        S_FIND: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            status         <= find_hit ? plk_pkg::ST_OK : plk_pkg::ST_NOT_FOUND;
            found_position <= find_pos;
            element        <= '0;
            length         <= fill;
            last           <= 1'b1;
            state          <= S_IDLE;
          end
        end
        S_TRAV: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            status         <= plk_pkg::ST_OK;
            found_position <= '0;
            element        <= cell_q[0];
            length         <= fill;
            last           <= (tcnt + CW'(1) == fill);
            tcnt           <= tcnt + CW'(1);
            if (tcnt + CW'(1) == fill) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/plk_cell.sv =====
// One list cell: holds an element, shifts with its neighbors, compares against a key.
`default_nettype none

module plk_cell #(
  parameter int CAPACITY = plk_pkg::CAPACITY_DEF,
  parameter int INDEX    = 0,
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  logic                        clk,
  input  plk_pkg::cell_op_t           op,
  input  logic [CW-1:0]               fill,
  input  logic [CW-1:0]               slot,
  input  logic [plk_pkg::DATA_W-1:0]  din,
  input  logic [plk_pkg::DATA_W-1:0]  left,
  input  logic [plk_pkg::DATA_W-1:0]  right,
  input  logic [plk_pkg::DATA_W-1:0]  head,
  output logic [plk_pkg::DATA_W-1:0]  q,
  output logic                        match
);

  localparam logic [CW-1:0] K      = CW'(INDEX);
  localparam logic [CW-1:0] K_NEXT = CW'(INDEX + 1);

  logic [plk_pkg::DATA_W-1:0] q_next;

  always_comb begin
    q_next = q;
    unique case (op)
      plk_pkg::OP_APPEND: begin
        if (K == fill) q_next = din;
      end
      plk_pkg::OP_INSERT: begin
        if (K == slot) q_next = din;
        else if (K > slot && K <= fill) q_next = left;
      end
      plk_pkg::OP_DELETE: begin
        if (K >= slot && K_NEXT < fill) q_next = right;
      end
      plk_pkg::OP_ROTATE: begin
        if (K_NEXT < fill) q_next = right;
        else if (K_NEXT == fill) q_next = head;
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

  assign match = (K < fill) && (q == din);

endmodule

`default_nettype wire
